FILE: hdl/htpd_pkg.sv
// Shared types and constants of the Huffman tree page decoder.
package htpd_pkg;

  localparam int PAGE_BYTES_DEF = 2048;
  localparam int NODE_COUNT_DEF = 4096;

  localparam int IDX_W = 12;
  localparam int CNT_W = 12;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic [2:0] KIND_INTER  = 3'd0;
  localparam logic [2:0] KIND_LEAF8  = 3'd1;
  localparam logic [2:0] KIND_LEAF16 = 3'd2;
  localparam logic [2:0] KIND_EOF    = 3'd3;
  localparam logic [2:0] KIND_EMPTY  = 3'd4;

  localparam logic [1:0] RES_BYTE  = 2'd0;
  localparam logic [1:0] RES_END   = 2'd1;
  localparam logic [1:0] RES_ERROR = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [15:0]      value;
  } node_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

FILE: hdl/htpd_node_table.sv
// Node table memory with a clearing sweep after reset and one registered read port.
module htpd_node_table #(
  parameter int NODE_COUNT = htpd_pkg::NODE_COUNT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [htpd_pkg::IDX_W-1:0] wr_idx_i,
  input  htpd_pkg::node_t           wr_node_i,
  input  logic                      rd_en_i,
  input  logic [htpd_pkg::IDX_W-1:0] rd_idx_i,
  output htpd_pkg::node_t           rd_node_o,
  output logic                      busy_o
);
  import htpd_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  node_t           mem [NODE_COUNT];
  node_t           rd_q;
  logic            rd_range_q;
  logic            clr_busy_q;
  logic [AW-1:0]   clr_addr_q;
  logic [31:0]     wr_ext;
  logic [31:0]     rd_ext;
  logic            wr_range;
  logic            rd_range;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  node_t           mem_wd;

  assign wr_ext   = 32'(wr_idx_i);
  assign rd_ext   = 32'(rd_idx_i);
  assign wr_range = wr_ext < 32'(NODE_COUNT);
  assign rd_range = rd_ext < 32'(NODE_COUNT);

  always_comb begin
    if (clr_busy_q) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '{kind: KIND_EMPTY, left: '0, right: '0, value: '0};
    end else begin
      mem_we = wr_en_i && wr_range;
      mem_wa = wr_ext[AW-1:0];
      mem_wd = wr_node_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(NODE_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_ext[AW-1:0]];
      rd_range_q <= rd_range;
    end
  end

  always_comb begin
    rd_node_o = rd_q;
    if (!rd_range_q || (rd_q.kind > KIND_EOF)) begin
      rd_node_o.kind = KIND_EMPTY;
    end
  end

  assign busy_o = clr_busy_q;

endmodule

FILE: hdl/htpd_result_stage.sv
// Result holding register and output register that mark the final result of each item.
module htpd_result_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              flush_i,
  input  htpd_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output htpd_pkg::result_t out_res_o,
  output logic              out_last_o
);
  import htpd_pkg::*;

  logic    pend_valid_q;
  result_t pend_q;
  logic    out_valid_q;
  result_t out_q;
  logic    out_last_q;

  assign ready_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ready_o && push_i) begin
        pend_valid_q <= 1'b1;
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
        end
      end else if (ready_o && flush_i) begin
        pend_valid_q <= 1'b0;
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      pend_q     <= res_i;
      out_q      <= pend_q;
      out_last_q <= 1'b0;
    end else if (ready_o && flush_i && pend_valid_q) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hdl/htpd_walker.sv
// Sequencer that walks the node table one bit at a time and produces results.
module htpd_walker #(
  parameter int PAGE_BYTES = htpd_pkg::PAGE_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [htpd_pkg::IDX_W-1:0] node_index_i,
  input  logic [2:0]                 node_kind_i,
  input  logic [htpd_pkg::IDX_W-1:0] left_child_i,
  input  logic [htpd_pkg::IDX_W-1:0] right_child_i,
  input  logic [15:0]                leaf_value_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [htpd_pkg::IDX_W-1:0] root_i,
  input  logic                       tbl_busy_i,
  output logic                       wr_en_o,
  output logic [htpd_pkg::IDX_W-1:0] wr_idx_o,
  output htpd_pkg::node_t            wr_node_o,
  output logic                       rd_en_o,
  output logic [htpd_pkg::IDX_W-1:0] rd_idx_o,
  input  htpd_pkg::node_t            rd_node_i,
  input  logic                       stage_ready_i,
  output logic                       push_o,
  output logic                       flush_o,
  output htpd_pkg::result_t          res_o
);
  import htpd_pkg::*;

  localparam int LW = $clog2(PAGE_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RDCUR, S_CHKCUR, S_CHKNEXT, S_EMIT, S_FLUSH
  } state_e;

  typedef enum logic [1:0] {ACT_LO, ACT_ADV, ACT_DONE} act_e;

  state_e           state_q, state_d;
  act_e             act_q, act_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] next_q, next_d;
  logic [LW-1:0]    len_q, len_d;
  logic             fin_q, fin_d;
  logic             start_q, start_d;
  logic [7:0]       data_q, data_d;
  logic [2:0]       bit_q, bit_d;
  logic [15:0]      val_q, val_d;
  result_t          res_q, res_d;
  logic             accept;
  logic [LW-1:0]    len_inc;
  logic [IDX_W-1:0] child;

  assign in_ready_o = (state_q == S_IDLE) && !tbl_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len_inc    = len_q + LW'(1);
  assign child      = data_q[bit_q] ? rd_node_i.left : rd_node_i.right;

  assign wr_en_o   = accept && (opcode_i == OP_LOAD);
  assign wr_idx_o  = node_index_i;
  assign wr_node_o = '{kind: node_kind_i, left: left_child_i, right: right_child_i,
                       value: leaf_value_i};

  assign rd_en_o  = (state_q == S_RDCUR) || (state_q == S_CHKCUR);
  assign rd_idx_o = (state_q == S_RDCUR) ? cur_q : child;
  assign res_o    = res_q;

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    cur_d   = cur_q;
    next_d  = next_q;
    len_d   = len_q;
    fin_d   = fin_q;
    start_d = start_q;
    data_d  = data_q;
    bit_d   = bit_q;
    val_d   = val_q;
    res_d   = res_q;
    push_o  = 1'b0;
    flush_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_START) begin
            len_d   = '0;
            fin_d   = 1'b0;
            cur_d   = root_i;
            start_d = 1'b1;
            state_d = S_RDCUR;
          end else if ((opcode_i == OP_DATA) && !fin_q) begin
            data_d  = data_byte_i;
            bit_d   = 3'd7;
            start_d = 1'b0;
            state_d = S_RDCUR;
          end
        end
      end
      S_RDCUR: begin
        state_d = S_CHKCUR;
      end
      S_CHKCUR: begin
        if (rd_node_i.kind != KIND_INTER) begin
          fin_d   = 1'b1;
          res_d   = '{kind: (rd_node_i.kind == KIND_EOF) ? RES_END : RES_ERROR,
                      data: '0, count: CNT_W'(len_q)};
          act_d   = ACT_DONE;
          state_d = S_EMIT;
        end else if (start_q) begin
          state_d = S_IDLE;
        end else begin
          next_d  = child;
          state_d = S_CHKNEXT;
        end
      end
      S_CHKNEXT: begin
        val_d = rd_node_i.value;
        if (rd_node_i.kind == KIND_INTER) begin
          cur_d = next_q;
          if (bit_q == 3'd0) begin
            state_d = S_FLUSH;
          end else begin
            bit_d   = bit_q - 3'd1;
            state_d = S_RDCUR;
          end
        end else if ((rd_node_i.kind == KIND_LEAF8) || (rd_node_i.kind == KIND_LEAF16)) begin
          if (len_q >= LW'(PAGE_BYTES)) begin
            fin_d   = 1'b1;
            res_d   = '{kind: RES_ERROR, data: '0, count: CNT_W'(len_q)};
            act_d   = ACT_DONE;
          end else begin
            len_d = len_inc;
            if (rd_node_i.kind == KIND_LEAF8) begin
              res_d = '{kind: RES_BYTE, data: rd_node_i.value[7:0], count: CNT_W'(len_inc)};
              act_d = ACT_ADV;
            end else begin
              res_d = '{kind: RES_BYTE, data: rd_node_i.value[15:8], count: CNT_W'(len_inc)};
              act_d = (len_inc < LW'(PAGE_BYTES)) ? ACT_LO : ACT_ADV;
            end
          end
          state_d = S_EMIT;
        end else begin
          fin_d   = 1'b1;
          res_d   = '{kind: (rd_node_i.kind == KIND_EOF) ? RES_END : RES_ERROR,
                      data: '0, count: CNT_W'(len_q)};
          act_d   = ACT_DONE;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stage_ready_i) begin
          push_o = 1'b1;
          case (act_q)
            ACT_LO: begin
              len_d = len_inc;
              res_d = '{kind: RES_BYTE, data: val_q[7:0], count: CNT_W'(len_inc)};
              act_d = ACT_ADV;
            end
            ACT_ADV: begin
              cur_d = root_i;
              if (bit_q == 3'd0) begin
                state_d = S_FLUSH;
              end else begin
                bit_d   = bit_q - 3'd1;
                state_d = S_RDCUR;
              end
            end
            default: begin
              state_d = S_FLUSH;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (stage_ready_i) begin
          flush_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_DONE;
      cur_q   <= '0;
      len_q   <= '0;
      fin_q   <= 1'b1;
      start_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
      start_q <= start_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q <= next_d;
    data_q <= data_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

endmodule

FILE: hdl/huffman_tree_page_decoder_core.sv
// Top level of the Huffman tree page decoder.
// Items are taken one at a time. A load item writes a node table entry. A start item
// reads the root node; when the root node ends the slice at once, it also emits an end
// or error result and a closing flush. A data byte is accepted and then walked bit by bit;
// each bit makes two dependent reads of the single node table read port, and each result
// is pushed to the result stage, a byte giving up to sixteen results, followed by one
// closing flush. A byte that ends the slice early stops walking, and a stalled output
// holds the walker. After reset the node table is cleared to empty entries, during
// which no item is taken; the root register can be written at any time. Each result
// waits in a holding stage until the next one is known, so the final result of an item
// carries last_result.
module huffman_tree_page_decoder_core #(
  parameter int PAGE_BYTES = htpd_pkg::PAGE_BYTES_DEF,
  parameter int NODE_COUNT = htpd_pkg::NODE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [htpd_pkg::IDX_W-1:0] node_index_i,
  input  logic [2:0]                 node_kind_i,
  input  logic [htpd_pkg::IDX_W-1:0] left_child_i,
  input  logic [htpd_pkg::IDX_W-1:0] right_child_i,
  input  logic [15:0]                leaf_value_i,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 result_kind_o,
  output logic [7:0]                 out_byte_o,
  output logic [htpd_pkg::CNT_W-1:0] out_count_o,
  output logic                       last_result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [htpd_pkg::IDX_W-1:0] cfg_data_i
);
  import htpd_pkg::*;

  logic [IDX_W-1:0] root_q;
  logic             in_ready;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  node_t            wr_node;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  node_t            rd_node;
  logic             tbl_busy;
  logic             stage_ready;
  logic             push;
  logic             flush;
  result_t          res;
  result_t          out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_q <= cfg_data_i;
    end
  end

  assign in_stall_o = !in_ready;

  htpd_node_table #(
    .NODE_COUNT(NODE_COUNT)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_node_i(wr_node),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx),
    .rd_node_o(rd_node),
    .busy_o   (tbl_busy)
  );

  htpd_walker #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode_i),
    .node_index_i (node_index_i),
    .node_kind_i  (node_kind_i),
    .left_child_i (left_child_i),
    .right_child_i(right_child_i),
    .leaf_value_i (leaf_value_i),
    .data_byte_i  (data_byte_i),
    .root_i       (root_q),
    .tbl_busy_i   (tbl_busy),
    .wr_en_o      (wr_en),
    .wr_idx_o     (wr_idx),
    .wr_node_o    (wr_node),
    .rd_en_o      (rd_en),
    .rd_idx_o     (rd_idx),
    .rd_node_i    (rd_node),
    .stage_ready_i(stage_ready),
    .push_o       (push),
    .flush_o      (flush),
    .res_o        (res)
  );

  htpd_result_stage u_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .flush_i    (flush),
    .res_i      (res),
    .ready_o    (stage_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res),
    .out_last_o (last_result_o)
  );

  assign result_kind_o = out_res.kind;
  assign out_byte_o    = out_res.data;
  assign out_count_o   = out_res.count;

endmodule
